/* rtl/bpa_pkg.sv */
// shared constants, types and codes of the buddy page allocator
package bpa_pkg;

  localparam int MAX_ORDER        = 10;
  localparam int PAGE_NUMBER_BITS = 12;
  localparam int PAGE_SIZE_BITS   = 12;

  localparam int NORDERS  = MAX_ORDER + 1;
  localparam int KW       = $clog2(NORDERS);
  localparam int LINK_W   = PAGE_NUMBER_BITS + 1;
  localparam int ORDER_W  = 4;
  localparam int SIZE_W   = 23;
  localparam int SPAN     = 1 << MAX_ORDER;
  localparam int SZW      = MAX_ORDER + PAGE_SIZE_BITS + 1;
  localparam int CW       = (SZW > SIZE_W) ? SZW + 1 : SIZE_W + 1;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(1) << PAGE_NUMBER_BITS;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOMEM   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REQ_ALLOC_ORDER = 2'd0,
    REQ_ALLOC_BYTES = 2'd1,
    REQ_FREE        = 2'd2,
    REQ_ADD         = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_SIZE,
    S_SEARCH,
    S_REM_WR,
    S_SPLIT,
    S_APP,
    S_APP_LINK,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_ADD_RD,
    S_ADD_CHK,
    S_FINISH
  } state_t;

  typedef enum logic {
    BU_ADD,
    BU_XOR
  } bu_op_t;

  // per-page descriptor
  typedef struct packed {
    logic               free_head;
    logic               used_head;
    logic [ORDER_W-1:0] order;
  } pinfo_t;

  // request to the shared page arithmetic unit
  typedef struct packed {
    bu_op_t                      op;
    logic [PAGE_NUMBER_BITS-1:0] base;
    logic [PAGE_NUMBER_BITS-1:0] offs;
  } bu_ctl_t;

endpackage

/* rtl/bpa_if.sv */
// request and response channel interfaces
interface bpa_req_if import bpa_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [ORDER_W-1:0]          order;
  logic [SIZE_W-1:0]           size_bytes;
  logic [PAGE_NUMBER_BITS-1:0] page_number;
  modport source (output valid, req_type, order, size_bytes, page_number, input ready);
  modport sink   (input valid, req_type, order, size_bytes, page_number, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [PAGE_NUMBER_BITS-1:0] granted_page;
  logic [ORDER_W-1:0]          granted_order;
  modport source (output valid, status, granted_page, granted_order, input ready);
  modport sink   (input valid, status, granted_page, granted_order, output ready);
endinterface

/* rtl/bpa_ram.sv */
// generic single write, single registered read ram
module bpa_ram #(
  parameter int WIDTH = 1,
  parameter int ABITS = 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [2**ABITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/bpa_page_unit.sv */
// shared page arithmetic: buddy, split half and scan addresses
module bpa_page_unit import bpa_pkg::*; (
  input  bu_ctl_t                     ctl,
  output logic [PAGE_NUMBER_BITS-1:0] page
);
  always_comb begin
    unique case (ctl.op)
      BU_ADD: page = ctl.base + ctl.offs;
      BU_XOR: page = ctl.base ^ ctl.offs;
      default: page = ctl.base;
    endcase
  end
endmodule

/* rtl/buddy_page_allocator.sv */
// buddy page allocator: top level with sequencer, free lists and page stores
// One request is handled at a time and gives one response. After reset a
// clearing pass wipes all 2^PAGE_NUMBER_BITS (4096) page descriptors; no
// request is taken meanwhile. Allocation takes the accept, a size step per
// order tried for a byte request, a search step per order searched upward,
// the list removal, a split and an append per split level (plus a link step
// if the list was not empty), the marking of the block as used and the
// finish state. A free accepts, reads and checks the block, then per merge
// level reads, checks and unlinks the buddy; a failed check (none is read at
// the top order) ends the merging, and the final append and finish follow.
// Adding a top-order block checks all 2^MAX_ORDER (1024) pages of its range
// through the descriptor read port, stopping at a busy page. All the page
// arithmetic goes through one shared adder/xor unit, and each list update
// is bound by the single write port of each link store. A response waits in
// an output register, so the next request is taken while it is still pending.
module buddy_page_allocator import bpa_pkg::*; (
  input logic      clk,
  input logic      rst,
  bpa_req_if.sink  req,
  bpa_rsp_if.source rsp
);
  localparam int PNB = PAGE_NUMBER_BITS;
  localparam logic [CW-1:0] MAX_BYTES = CW'(1) << (MAX_ORDER + PAGE_SIZE_BITS);
  localparam logic [KW-1:0] K_MAX = KW'(MAX_ORDER);

  state_t state, state_next;

  // request context
  req_t               req_kind;
  logic [KW-1:0]      want, want_next;
  logic [KW-1:0]      k, k_next;
  logic [PNB-1:0]     p, p_next;
  logic [PNB-1:0]     tgt, tgt_next;
  logic [PNB-1:0]     t_link, t_link_next;
  logic [MAX_ORDER-1:0] scan, scan_next;
  logic [SIZE_W-1:0]  size;
  logic [PNB-1:0]     clr;

  status_t            res_status, res_status_next;
  logic [PNB-1:0]     res_page, res_page_next;
  logic [ORDER_W-1:0] res_order, res_order_next;

  // free list ends and lengths
  logic [LINK_W-1:0] head  [NORDERS];
  logic [LINK_W-1:0] tail  [NORDERS];
  logic [LINK_W-1:0] count [NORDERS];
  logic              head_we, tail_we, cnt_inc, cnt_dec;
  logic [LINK_W-1:0] head_wd, tail_wd;

  // output register
  logic               out_valid;
  status_t            out_status;
  logic [PNB-1:0]     out_page;
  logic [ORDER_W-1:0] out_order;

  // stores
  logic           pi_we;
  logic [PNB-1:0] pi_waddr, pi_raddr;
  pinfo_t         pi_wdata, pi_rd;
  logic           nx_we, pv_we;
  logic [PNB-1:0] nx_waddr, pv_waddr, ln_raddr;
  logic [LINK_W-1:0] nx_wdata, pv_wdata, nx_rd, pv_rd;

  bu_ctl_t        bu;
  logic [PNB-1:0] bu_page;

  bpa_ram #(.WIDTH($bits(pinfo_t)), .ABITS(PNB)) u_pinfo (
    .clk(clk), .we(pi_we), .waddr(pi_waddr), .wdata(pi_wdata),
    .raddr(pi_raddr), .rdata(pi_rd)
  );
  bpa_ram #(.WIDTH(LINK_W), .ABITS(PNB)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(ln_raddr), .rdata(nx_rd)
  );
  bpa_ram #(.WIDTH(LINK_W), .ABITS(PNB)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(ln_raddr), .rdata(pv_rd)
  );
  bpa_page_unit u_unit (.ctl(bu), .page(bu_page));

  // decision terms shared by the sequencer and the datapath
  logic acc, out_free, is_alloc;
  logic [LINK_W-1:0] head_k, tail_k, cnt_k;
  logic size_bad, size_grow, mrg_match, chk_bad, scan_last, t_nil;
  logic [CW-1:0] size_ext, pow;

  assign acc      = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign is_alloc = (req_kind == REQ_ALLOC_ORDER) || (req_kind == REQ_ALLOC_BYTES);
  assign head_k   = head[k];
  assign tail_k   = tail[k];
  assign cnt_k    = count[k];
  assign t_nil    = tail_k[PNB];
  assign size_ext = CW'(req.size_bytes);
  assign size_bad = (req.size_bytes == '0) || (size_ext > MAX_BYTES);
  assign pow      = CW'(1) << (32'(want) + PAGE_SIZE_BITS);
  assign size_grow = (want < K_MAX) && (pow < CW'(size));
  assign mrg_match = pi_rd.free_head && (pi_rd.order == ORDER_W'(k));
  assign chk_bad   = pi_rd.free_head || pi_rd.used_head;
  assign scan_last = scan == MAX_ORDER'(SPAN - 1);

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.granted_page  = out_page;
  assign rsp.granted_order = out_order;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (clr == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          unique case (req_t'(req.req_type))
            REQ_ALLOC_ORDER: state_next = (req.order > ORDER_W'(MAX_ORDER)) ? S_FINISH
                                                                              : S_SEARCH;
            REQ_ALLOC_BYTES: state_next = size_bad ? S_FINISH : S_SIZE;
            REQ_FREE:        state_next = S_FREE_RD;
            REQ_ADD:         state_next = (req.page_number[MAX_ORDER-1:0] != '0) ? S_FINISH
                                                                                  : S_ADD_RD;
            default:         state_next = S_FINISH;
          endcase
        end
      end
      S_SIZE:     if (!size_grow) state_next = S_SEARCH;
      S_SEARCH: begin
        if (cnt_k != '0) state_next = head_k[PNB] ? S_FINISH : S_REM_WR;
        else if (k == K_MAX) state_next = S_FINISH;
      end
      S_REM_WR:   state_next = is_alloc ? S_SPLIT : S_MERGE_RD;
      S_SPLIT:    state_next = (k > want) ? S_APP : S_FINISH;
      S_APP:      state_next = !t_nil ? S_APP_LINK : (is_alloc ? S_SPLIT : S_FINISH);
      S_APP_LINK: state_next = is_alloc ? S_SPLIT : S_FINISH;
      S_FREE_RD:  state_next = S_FREE_CHK;
      S_FREE_CHK: state_next = pi_rd.used_head ? S_MERGE_RD : S_FINISH;
      S_MERGE_RD: state_next = (k < K_MAX) ? S_MERGE_CHK : S_APP;
      S_MERGE_CHK: state_next = mrg_match ? S_REM_WR : S_APP;
      S_ADD_RD:   state_next = S_ADD_CHK;
      S_ADD_CHK: begin
        if (chk_bad) state_next = S_FINISH;
        else if (scan_last) state_next = S_APP;
        else state_next = S_ADD_RD;
      end
      S_FINISH:   if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath and store ports
  always_comb begin
    want_next = want;  k_next = k;  p_next = p;  tgt_next = tgt;
    t_link_next = t_link;  scan_next = scan;
    res_status_next = res_status;  res_page_next = res_page;  res_order_next = res_order;
    pi_we = 1'b0;  pi_waddr = p;  pi_wdata = '0;  pi_raddr = p;
    nx_we = 1'b0;  nx_waddr = tgt;  nx_wdata = NIL_LINK;
    pv_we = 1'b0;  pv_waddr = tgt;  pv_wdata = tail_k;
    ln_raddr = tgt;
    head_we = 1'b0;  head_wd = '0;  tail_we = 1'b0;  tail_wd = '0;
    cnt_inc = 1'b0;  cnt_dec = 1'b0;
    bu.op = BU_ADD;  bu.base = p;  bu.offs = '0;
    unique case (state)
      S_CLEAR: begin
        pi_we = 1'b1;  pi_waddr = clr;
      end
      S_IDLE: begin
        if (acc) begin
          res_status_next = ST_OK;  res_page_next = '0;  res_order_next = '0;
          p_next = req.page_number;  scan_next = '0;
          want_next = KW'(req.order);  k_next = KW'(req.order);
          unique case (req_t'(req.req_type))
            REQ_ALLOC_ORDER: if (req.order > ORDER_W'(MAX_ORDER)) res_status_next = ST_INVALID;
            REQ_ALLOC_BYTES: begin
              want_next = '0;
              if (size_bad) res_status_next = ST_INVALID;
            end
            REQ_FREE: ;
            REQ_ADD: if (req.page_number[MAX_ORDER-1:0] != '0) res_status_next = ST_INVALID;
            default: ;
          endcase
        end
      end
      S_SIZE: begin
        if (size_grow) want_next = want + KW'(1);
        else k_next = want;
      end
      S_SEARCH: begin
        // issue link read for the list head at once
        ln_raddr = head_k[PNB-1:0];
        if (cnt_k != '0) begin
          p_next = head_k[PNB-1:0];  tgt_next = head_k[PNB-1:0];
          if (head_k[PNB]) res_status_next = ST_NOMEM;
        end else if (k == K_MAX) begin
          res_status_next = ST_NOMEM;
        end else begin
          k_next = k + KW'(1);
        end
      end
      S_REM_WR: begin
        // unlink tgt from list k
        if (pv_rd[PNB]) begin
          head_we = 1'b1;  head_wd = nx_rd;
        end else begin
          nx_we = 1'b1;  nx_waddr = pv_rd[PNB-1:0];  nx_wdata = nx_rd;
        end
        if (nx_rd[PNB]) begin
          tail_we = 1'b1;  tail_wd = pv_rd;
        end else begin
          pv_we = 1'b1;  pv_waddr = nx_rd[PNB-1:0];  pv_wdata = pv_rd;
        end
        cnt_dec = 1'b1;
        if (!is_alloc) begin
          if (tgt < p) p_next = tgt;
          k_next = k + KW'(1);
        end
      end
      S_SPLIT: begin
        bu.op = BU_ADD;  bu.offs = PNB'(1) << (k - KW'(1));
        if (k > want) begin
          k_next = k - KW'(1);  tgt_next = bu_page;
          pi_we = 1'b1;  pi_waddr = bu_page;
          pi_wdata = '{free_head: 1'b1, used_head: 1'b0, order: ORDER_W'(k - KW'(1))};
        end else begin
          pi_we = 1'b1;  pi_waddr = p;
          pi_wdata = '{free_head: 1'b0, used_head: 1'b1, order: ORDER_W'(want)};
          res_page_next = p;  res_order_next = ORDER_W'(want);
        end
      end
      S_APP: begin
        nx_we = 1'b1;  nx_waddr = tgt;  nx_wdata = NIL_LINK;
        pv_we = 1'b1;  pv_waddr = tgt;  pv_wdata = tail_k;
        if (t_nil) begin
          head_we = 1'b1;  head_wd = {1'b0, tgt};
        end
        tail_we = 1'b1;  tail_wd = {1'b0, tgt};
        cnt_inc = 1'b1;
        t_link_next = tail_k[PNB-1:0];
      end
      S_APP_LINK: begin
        nx_we = 1'b1;  nx_waddr = t_link;  nx_wdata = {1'b0, tgt};
      end
      S_FREE_RD: pi_raddr = p;
      S_FREE_CHK: begin
        if (pi_rd.used_head) begin
          pi_we = 1'b1;  pi_waddr = p;
          k_next = (pi_rd.order > ORDER_W'(MAX_ORDER)) ? K_MAX : KW'(pi_rd.order);
        end else begin
          res_status_next = ST_INVALID;
        end
      end
      S_MERGE_RD: begin
        bu.op = BU_XOR;  bu.offs = PNB'(1) << k;
        if (k < K_MAX) begin
          pi_raddr = bu_page;  tgt_next = bu_page;
        end else begin
          pi_we = 1'b1;  pi_waddr = p;
          pi_wdata = '{free_head: 1'b1, used_head: 1'b0, order: ORDER_W'(k)};
          tgt_next = p;
        end
      end
      S_MERGE_CHK: begin
        if (mrg_match) begin
          pi_we = 1'b1;  pi_waddr = tgt;  ln_raddr = tgt;
        end else begin
          pi_we = 1'b1;  pi_waddr = p;
          pi_wdata = '{free_head: 1'b1, used_head: 1'b0, order: ORDER_W'(k)};
          tgt_next = p;
        end
      end
      S_ADD_RD: begin
        bu.op = BU_ADD;  bu.offs = PNB'(scan);
        pi_raddr = bu_page;
      end
      S_ADD_CHK: begin
        if (chk_bad) begin
          res_status_next = ST_INVALID;
        end else if (scan_last) begin
          pi_we = 1'b1;  pi_waddr = p;
          pi_wdata = '{free_head: 1'b1, used_head: 1'b0, order: ORDER_W'(MAX_ORDER)};
          tgt_next = p;  k_next = K_MAX;
        end else begin
          scan_next = scan + MAX_ORDER'(1);
        end
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < NORDERS; j++) begin
        head[j]  <= NIL_LINK;
        tail[j]  <= NIL_LINK;
        count[j] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + PNB'(1);
      if (head_we) head[k] <= head_wd;
      if (tail_we) tail[k] <= tail_wd;
      if (cnt_inc) count[k] <= count[k] + LINK_W'(1);
      else if (cnt_dec && count[k] != '0) count[k] <= count[k] - LINK_W'(1);
      if (state == S_FINISH && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    want <= want_next;  k <= k_next;  p <= p_next;  tgt <= tgt_next;
    t_link <= t_link_next;  scan <= scan_next;
    res_status <= res_status_next;  res_page <= res_page_next;  res_order <= res_order_next;
    if (acc) req_kind <= req_t'(req.req_type);
    if (acc) size <= req.size_bytes;
    if (state == S_FINISH && out_free) begin
      out_status <= res_status;  out_page <= res_page;  out_order <= res_order;
    end
  end

  // no request is taken during the clearing pass
  assert property (@(posedge clk) disable iff (rst) state == S_CLEAR |-> !req.ready)
    else $error("request taken during clearing pass");
  // a failed response carries no grant
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.granted_page == '0 && rsp.granted_order == '0)
    else $error("grant on failed response");
  // granted order never exceeds the top order
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.granted_order <= ORDER_W'(MAX_ORDER))
    else $error("granted order out of range");
  // an empty top list has no members
  assert property (@(posedge clk) disable iff (rst)
    head[MAX_ORDER][PNB] |-> count[MAX_ORDER] == '0)
    else $error("top list head and count disagree");
endmodule
